FILE: hw/rtl/s2c_pkg.sv
`default_nettype none
package s2c_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ANG_W = 35;
    localparam int CW    = 34;
    localparam int PW    = 70;

    localparam logic signed [15:0] PI_Q12     = 16'sd12868;
    localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [CW-1:0]    GAIN_Q30    = 34'sd652032874;

    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [CW-1:0] v;
        case (idx)
            5'd0:    v = 34'sh3243F6A8;
            5'd1:    v = 34'sh1DAC6705;
            5'd2:    v = 34'sh0FADBAFC;
            5'd3:    v = 34'sh07F56EA6;
            5'd4:    v = 34'sh03FEAB76;
            5'd5:    v = 34'sh01FFD55B;
            5'd6:    v = 34'sh00FFFAAA;
            5'd7:    v = 34'sh007FFF55;
            5'd8:    v = 34'sh003FFFEA;
            5'd9:    v = 34'sh001FFFFD;
            5'd10:   v = 34'sh000FFFFF;
            5'd11:   v = 34'sh0007FFFF;
            5'd12:   v = 34'sh0003FFFF;
            5'd13:   v = 34'sh0001FFFF;
            5'd14:   v = 34'sh0000FFFF;
            5'd15:   v = 34'sh00007FFF;
            5'd16:   v = 34'sh00003FFF;
            5'd17:   v = 34'sh00001FFF;
            5'd18:   v = 34'sh00000FFF;
            5'd19:   v = 34'sh000007FF;
            5'd20:   v = 34'sh000003FF;
            5'd21:   v = 34'sh000001FF;
            5'd22:   v = 34'sh000000FF;
            5'd23:   v = 34'sh0000007F;
            5'd24:   v = 34'sh0000003F;
            5'd25:   v = 34'sh0000001F;
            5'd26:   v = 34'sh0000000F;
            5'd27:   v = 34'sh00000008;
            5'd28:   v = 34'sh00000004;
            5'd29:   v = 34'sh00000002;
            5'd30:   v = 34'sh00000001;
            default: v = 34'sh00000000;
        endcase
        return v;
    endfunction

    // clamp to the signed q8.8 range
    function automatic logic signed [15:0] sat16(input logic signed [PW-1:0] v);
        logic signed [15:0] s;
        if (v > 70'sd32767) begin
            s = 16'sh7FFF;
        end else if (v < -70'sd32768) begin
            s = 16'sh8000;
        end else begin
            s = v[15:0];
        end
        return s;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/s2c_stream_if.sv
`default_nettype none
interface s2c_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] radius_in;
    logic signed [15:0] polar_in;
    logic signed [15:0] azimuth_in;
    modport source (output valid, radius_in, polar_in, azimuth_in, input ready);
    modport sink   (input valid, radius_in, polar_in, azimuth_in, output ready);
endinterface

interface s2c_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x_out;
    logic signed [15:0] y_out;
    logic signed [15:0] z_out;
    modport source (output valid, x_out, y_out, z_out, input ready);
    modport sink   (input valid, x_out, y_out, z_out, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/s2c_cordic.sv
`default_nettype none
module s2c_cordic #(
    parameter int STAGES = s2c_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_en,
    input  wire logic                             i_valid,
    input  wire logic signed [15:0]               i_ang [2],
    input  wire logic signed [15:0]               i_r,
    output logic                                  o_valid,
    output logic signed [s2c_pkg::CW-1:0]         o_cos [2],
    output logic signed [s2c_pkg::CW-1:0]         o_sin [2],
    output logic signed [15:0]                    o_r
);
    localparam int CW = s2c_pkg::CW;
    localparam int AW = s2c_pkg::ANG_W;

    // lane 0 is the polar angle, lane 1 the azimuth
    logic                 r_vb;
    logic signed [15:0]   r_rb;
    logic signed [AW-1:0] r_zb [2];

    logic                 r_v   [STAGES+1];
    logic signed [15:0]   r_r   [STAGES+1];
    logic                 r_neg [STAGES+1][2];
    logic signed [CW-1:0] r_x   [STAGES+1][2];
    logic signed [CW-1:0] r_y   [STAGES+1][2];
    logic signed [CW-1:0] r_z   [STAGES+1][2];

    logic                 r_vo;
    logic signed [15:0]   r_ro;
    logic signed [CW-1:0] r_co [2];
    logic signed [CW-1:0] r_so [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
            r_vo <= 1'b0;
            for (int s = 0; s <= STAGES; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_vb <= i_valid;
            r_v[0] <= r_vb;
            for (int s = 0; s < STAGES; s++) begin
                r_v[s+1] <= r_v[s];
            end
            r_vo <= r_v[STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [AW-1:0] n_w;
        logic signed [AW-1:0] n_f;
        if (i_en) begin
            r_rb <= i_r;
            r_r[0] <= r_rb;
            for (int s = 0; s < STAGES; s++) begin
                r_r[s+1] <= r_r[s];
            end
            r_ro <= r_r[STAGES];
            for (int l = 0; l < 2; l++) begin
                // widen q4.12 to q30 and bring into -pi..pi
                n_w = AW'(i_ang[l]) <<< 18;
                if (n_w > s2c_pkg::PI_Q30) begin
                    r_zb[l] <= n_w - s2c_pkg::TWO_PI_Q30;
                end else if (n_w < -s2c_pkg::PI_Q30) begin
                    r_zb[l] <= n_w + s2c_pkg::TWO_PI_Q30;
                end else begin
                    r_zb[l] <= n_w;
                end
                // fold into -pi/2..pi/2, negating the result later
                if (r_zb[l] > s2c_pkg::HALF_PI_Q30) begin
                    n_f = r_zb[l] - s2c_pkg::PI_Q30;
                    r_neg[0][l] <= 1'b1;
                end else if (r_zb[l] < -s2c_pkg::HALF_PI_Q30) begin
                    n_f = r_zb[l] + s2c_pkg::PI_Q30;
                    r_neg[0][l] <= 1'b1;
                end else begin
                    n_f = r_zb[l];
                    r_neg[0][l] <= 1'b0;
                end
                r_z[0][l] <= n_f[CW-1:0];
                r_x[0][l] <= s2c_pkg::GAIN_Q30;
                r_y[0][l] <= '0;
                for (int s = 0; s < STAGES; s++) begin
                    r_neg[s+1][l] <= r_neg[s][l];
                end
                r_co[l] <= r_neg[STAGES][l] ? -r_x[STAGES][l] : r_x[STAGES][l];
                r_so[l] <= r_neg[STAGES][l] ? -r_y[STAGES][l] : r_y[STAGES][l];
            end
        end
    end

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        for (genvar l = 0; l < 2; l++) begin : g_lane
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (r_z[s][l] >= 0) begin
                        r_x[s+1][l] <= r_x[s][l] - (r_y[s][l] >>> s);
                        r_y[s+1][l] <= r_y[s][l] + (r_x[s][l] >>> s);
                        r_z[s+1][l] <= r_z[s][l] - s2c_pkg::atan_q30(5'(s));
                    end else begin
                        r_x[s+1][l] <= r_x[s][l] + (r_y[s][l] >>> s);
                        r_y[s+1][l] <= r_y[s][l] - (r_x[s][l] >>> s);
                        r_z[s+1][l] <= r_z[s][l] + s2c_pkg::atan_q30(5'(s));
                    end
                end
            end
        end
    end

    assign o_valid = r_vo;
    assign o_r     = r_ro;
    assign o_cos   = r_co;
    assign o_sin   = r_so;

endmodule
`default_nettype wire

FILE: hw/rtl/spherical_to_cartesian_unit.sv
`default_nettype none
// spherical to cartesian conversion, fully pipelined
// throughput: one transaction per cycle while the output is not held; the shift-add cordic stages set the depth
// a held result stalls the whole pipeline together, nothing is dropped
// reset (synchronous, active low) clears every valid bit; data registers keep contents
module spherical_to_cartesian_unit #(
    parameter int CORDIC_STAGES = s2c_pkg::CORDIC_STAGES_DEF
) (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    s2c_in_if.sink      i_pt,
    s2c_out_if.source   o_xyz
);
    localparam int CW = s2c_pkg::CW;
    localparam int PW = s2c_pkg::PW;

    // pipeline advances whenever the output register is free or being drained
    logic en;
    assign en         = !o_xyz.valid || o_xyz.ready;
    assign i_pt.ready = en;

    // stage a: input validation
    logic               r_va;
    logic signed [15:0] r_ra;
    logic signed [15:0] r_ang [2];

    logic signed [16:0] az_ext;
    logic signed [16:0] az_mag;
    logic signed [16:0] az_red;
    logic signed [16:0] az_fix;

    always_comb begin
        az_ext = 17'(i_pt.azimuth_in);
        az_mag = (az_ext < 0) ? -az_ext : az_ext;
        // magnitude is below twice 2*pi, so one subtract does the remainder
        az_red = (az_mag >= s2c_pkg::TWO_PI_Q12) ? az_mag - s2c_pkg::TWO_PI_Q12 : az_mag;
        az_fix = (az_ext < 0) ? -az_red : az_red;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (en) begin
            r_va <= i_pt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ra <= (i_pt.radius_in < 0) ? 16'sd0 : i_pt.radius_in;
            if (i_pt.polar_in < 0) begin
                r_ang[0] <= 16'sd0;
            end else if (i_pt.polar_in > s2c_pkg::PI_Q12) begin
                r_ang[0] <= s2c_pkg::PI_Q12;
            end else begin
                r_ang[0] <= i_pt.polar_in;
            end
            r_ang[1] <= az_fix[15:0];
        end
    end

    // sine and cosine of both angles, radius rides along
    logic               c_v;
    logic signed [15:0] c_r;
    logic signed [CW-1:0] c_cos [2];
    logic signed [CW-1:0] c_sin [2];

    s2c_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_va),
        .i_ang   (r_ang),
        .i_r     (r_ra),
        .o_valid (c_v),
        .o_cos   (c_cos),
        .o_sin   (c_sin),
        .o_r     (c_r)
    );

    // stage m1: r*sin(theta) scaled to q23, r*cos(theta) kept whole
    logic               r_v1;
    logic signed [CW:0] r_rs;
    logic signed [49:0] r_rct;
    logic signed [CW-1:0] r_cp1;
    logic signed [CW-1:0] r_sp1;
    logic signed [49:0] n_rst;

    // stage m2: products with the azimuth terms; r*cos(theta) passes through for z
    logic               r_v2;
    logic signed [PW-1:0] r_px;
    logic signed [PW-1:0] r_py;
    logic signed [49:0] r_pz;

    // stage m3: rounding and saturation into the output register
    logic               r_vo;
    logic signed [15:0] r_xo;
    logic signed [15:0] r_yo;
    logic signed [15:0] r_zo;

    logic signed [PW-1:0] n_xr;
    logic signed [PW-1:0] n_yr;
    logic signed [PW-1:0] n_zr;

    always_comb begin
        n_rst = 50'(c_r) * 50'(c_sin[0]);
        n_xr  = (r_px + (PW'(1) <<< 44)) >>> 45;
        n_yr  = (r_py + (PW'(1) <<< 44)) >>> 45;
        n_zr  = (PW'(r_pz) + (PW'(1) <<< 29)) >>> 30;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else if (en) begin
            r_v1 <= c_v;
            r_v2 <= r_v1;
            r_vo <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rs  <= n_rst[49:15];
            r_rct <= 50'(c_r) * 50'(c_cos[0]);
            r_cp1 <= c_cos[1];
            r_sp1 <= c_sin[1];
            r_px  <= PW'(r_rs) * PW'(r_cp1);
            r_py  <= PW'(r_rs) * PW'(r_sp1);
            r_pz  <= r_rct;
            r_xo  <= s2c_pkg::sat16(n_xr);
            r_yo  <= s2c_pkg::sat16(n_yr);
            r_zo  <= s2c_pkg::sat16(n_zr);
        end
    end

    assign o_xyz.valid = r_vo;
    assign o_xyz.x_out = r_xo;
    assign o_xyz.y_out = r_yo;
    assign o_xyz.z_out = r_zo;

endmodule
`default_nettype wire
